>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ACD_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ACD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/acd_pkg.sv
package acd_pkg;

   // Number of trailing bytes that hold the stored CRC.
   localparam int TAIL_BYTES = 4;

   // Bytes in one section header; also the divisor of the plausibility check.
   localparam int SECTION_HDR_BYTES = 25;

   // Parse phases, which double as the field kind of each byte.
   localparam logic [3:0] PH_MAGIC        = 4'd0;
   localparam logic [3:0] PH_VERSION      = 4'd1;
   localparam logic [3:0] PH_FLAGS        = 4'd2;
   localparam logic [3:0] PH_COUNT        = 4'd3;
   localparam logic [3:0] PH_TYPE         = 4'd4;
   localparam logic [3:0] PH_COMPRESSION  = 4'd5;
   localparam logic [3:0] PH_SECTION_CRC  = 4'd6;
   localparam logic [3:0] PH_RAW_SIZE     = 4'd7;
   localparam logic [3:0] PH_PAYLOAD_SIZE = 4'd8;
   localparam logic [3:0] PH_PAYLOAD      = 4'd9;
   localparam logic [3:0] PH_TRAILER      = 4'd10;

   // End-of-archive status codes.
   localparam logic [2:0] ST_OK             = 3'd0;
   localparam logic [2:0] ST_TOO_SMALL      = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC      = 3'd2;
   localparam logic [2:0] ST_BAD_VERSION    = 3'd3;
   localparam logic [2:0] ST_IMPLAUSIBLE    = 3'd4;
   localparam logic [2:0] ST_TRUNCATED      = 3'd5;
   localparam logic [2:0] ST_CRC_MISMATCH   = 3'd6;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAGIC       = 2'd0;
   localparam logic [1:0] CSR_MIN_VERSION = 2'd1;
   localparam logic [1:0] CSR_MAX_VERSION = 2'd2;

   // Reflected CRC-32 constants.
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] magic;
      logic [31:0] min_version;
      logic [31:0] max_version;
   } csr_regs_type;

   // What the parser reports for the byte being accepted.
   typedef struct packed {
      logic [3:0]  kind;
      logic        complete;
      logic [63:0] value;
      logic [15:0] section;
      logic [3:0]  phase_next;
      logic [63:0] declared_next;
      logic        bad_magic;
      logic        bad_version;
      logic        crc_present;
   } parse_result_type;

   // Width in bytes of each header field.
   function automatic logic [3:0] field_width(input logic [3:0] phase);
      logic [3:0] w;
      case (phase)
         PH_MAGIC, PH_VERSION, PH_FLAGS, PH_TYPE, PH_SECTION_CRC: w = 4'd4;
         PH_COUNT, PH_RAW_SIZE, PH_PAYLOAD_SIZE:                   w = 4'd8;
         PH_COMPRESSION:                                           w = 4'd1;
         default:                                                  w = 4'd1;
      endcase
      return w;
   endfunction

   // One byte of the reflected CRC-32, one bit per step.
   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/archive_container_deframer_core.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    data_byte, is_final
// rsp_      out        rsp_valid/rsp_ready    field kind, byte, field value, section, status
// csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// Each request gives exactly one response, in the cycle after it is accepted.
// A new request is taken every cycle unless a response stalls; responses are registered.
// Synchronous active-high reset clears the parse state and loads the register defaults.
// A stalled response holds the output register, and req_ready drops until it is taken.
// The CSR port is always ready; every archive restarts from scratch after its final byte.
module archive_container_deframer_core #(
   parameter int MIN_ARCHIVE_BYTES  = 24,
   parameter int SECTION_INDEX_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_final,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_field_kind,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_field_complete,
   output logic [63:0] rsp_field_value,
   output logic [15:0] rsp_section_number,
   output logic        rsp_archive_end,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int SMALL_MAX = (MIN_ARCHIVE_BYTES > acd_pkg::TAIL_BYTES) ?
                              MIN_ARCHIVE_BYTES : acd_pkg::TAIL_BYTES;
   localparam int SMALL_W = $clog2(SMALL_MAX + 1);
   localparam logic [SMALL_W-1:0] SMALL_TOP = SMALL_W'(SMALL_MAX);
   localparam logic [SMALL_W-1:0] MIN_CNT   = SMALL_W'(MIN_ARCHIVE_BYTES);
   localparam logic [SMALL_W-1:0] TAIL_CNT  = SMALL_W'(acd_pkg::TAIL_BYTES);
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Q_MAX = ALL_ONES / acd_pkg::SECTION_HDR_BYTES;
   localparam logic [4:0]  R_MAX = 5'(ALL_ONES % acd_pkg::SECTION_HDR_BYTES);
   localparam logic [4:0]  R_WRAP = 5'(acd_pkg::SECTION_HDR_BYTES - 1);

   acd_pkg::csr_regs_type     regs_ff;
   acd_pkg::parse_result_type parse;

   logic               accept;
   logic               clear;
   logic               crc_match;
   logic [SMALL_W-1:0] small_ff, small_in;
   logic [4:0]         rem_ff, rem_in;
   logic [63:0]        quot_ff, quot_in;
   logic [2:0]         status;

   logic        rsp_valid_ff;
   logic [3:0]  kind_ff;
   logic [7:0]  byte_ff;
   logic        complete_ff;
   logic [63:0] value_ff;
   logic [15:0] section_ff;
   logic        end_ff;
   logic [2:0]  status_ff;

   assign accept    = req_valid && req_ready;
   assign clear     = req_is_final;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.magic       <= 32'd0;
         regs_ff.min_version <= 32'd1;
         regs_ff.max_version <= 32'd2;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            acd_pkg::CSR_MAGIC:       regs_ff.magic       <= csr_data;
            acd_pkg::CSR_MIN_VERSION: regs_ff.min_version <= csr_data;
            acd_pkg::CSR_MAX_VERSION: regs_ff.max_version <= csr_data;
            default: ;
         endcase
      end
   end

   acd_parser #(
      .SECTION_INDEX_BITS(SECTION_INDEX_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept),
      .clear     (clear),
      .data_byte (req_data_byte),
      .regs      (regs_ff),
      .result    (parse)
   );

   acd_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept),
      .clear     (clear),
      .started   (small_ff >= TAIL_CNT),
      .data_byte (req_data_byte),
      .crc_match (crc_match)
   );

   // Byte counting: a short saturating count for the size checks, and the
   // total kept as quotient and remainder by the section header size.
   always_comb begin
      small_in = (small_ff == SMALL_TOP) ? small_ff : small_ff + 1'b1;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (!(quot_ff == Q_MAX && rem_ff == R_MAX)) begin
         if (rem_ff == R_WRAP) begin
            rem_in  = 5'd0;
            quot_in = quot_ff + 64'd1;
         end else begin
            rem_in = rem_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && clear)) begin
         small_ff <= '0;
         rem_ff   <= 5'd0;
         quot_ff  <= 64'd0;
      end else if (accept) begin
         small_ff <= small_in;
         rem_ff   <= rem_in;
         quot_ff  <= quot_in;
      end
   end

   // End-of-archive status in priority order.
   always_comb begin
      if (small_in < MIN_CNT) begin
         status = acd_pkg::ST_TOO_SMALL;
      end else if (parse.bad_magic) begin
         status = acd_pkg::ST_BAD_MAGIC;
      end else if (parse.bad_version) begin
         status = acd_pkg::ST_BAD_VERSION;
      end else if (parse.phase_next > acd_pkg::PH_COUNT &&
                   parse.declared_next > quot_in + 64'd1) begin
         status = acd_pkg::ST_IMPLAUSIBLE;
      end else if (parse.phase_next != acd_pkg::PH_TRAILER) begin
         status = acd_pkg::ST_TRUNCATED;
      end else if (parse.crc_present && !crc_match) begin
         status = acd_pkg::ST_CRC_MISMATCH;
      end else begin
         status = acd_pkg::ST_OK;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= parse.kind;
         byte_ff     <= req_data_byte;
         complete_ff <= parse.complete;
         value_ff    <= parse.value;
         section_ff  <= parse.section;
         end_ff      <= req_is_final;
         status_ff   <= req_is_final ? status : acd_pkg::ST_OK;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_field_kind     = kind_ff;
   assign rsp_byte_out       = byte_ff;
   assign rsp_field_complete = complete_ff;
   assign rsp_field_value    = value_ff;
   assign rsp_section_number = section_ff;
   assign rsp_archive_end    = end_ff;
   assign rsp_status         = status_ff;

endmodule

>>> rtl/acd_crc.sv
module acd_crc (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       clear,
   input  logic       started,
   input  logic [7:0] data_byte,
   output logic       crc_match
);

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [7:0]  tail_ff [acd_pkg::TAIL_BYTES];
   logic [7:0]  tail_in [acd_pkg::TAIL_BYTES];
   logic [31:0] stored;

   // The oldest delayed byte enters the CRC once four bytes have been seen.
   always_comb begin
      crc_in = started ? acd_pkg::crc_step(crc_ff, tail_ff[0]) : crc_ff;
      for (int k = 0; k < acd_pkg::TAIL_BYTES - 1; k++) begin
         tail_in[k] = tail_ff[k + 1];
      end
      tail_in[acd_pkg::TAIL_BYTES - 1] = data_byte;
      stored    = {tail_in[3], tail_in[2], tail_in[1], tail_in[0]};
      crc_match = (stored == ~crc_in);
   end

   // The CRC and the delay line restart after each archive.
   always_ff @(posedge clock) begin
      if (reset || (advance && clear)) begin
         crc_ff <= acd_pkg::CRC_INIT;
         for (int k = 0; k < acd_pkg::TAIL_BYTES; k++) begin
            tail_ff[k] <= 8'd0;
         end
      end else if (advance) begin
         crc_ff <= crc_in;
         for (int k = 0; k < acd_pkg::TAIL_BYTES; k++) begin
            tail_ff[k] <= tail_in[k];
         end
      end
   end

endmodule

>>> rtl/acd_parser.sv
module acd_parser #(
   parameter int SECTION_INDEX_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      clear,
   input  logic [7:0]                data_byte,
   input  acd_pkg::csr_regs_type     regs,
   output acd_pkg::parse_result_type result
);

   localparam int CNT_W = (SECTION_INDEX_BITS >= 16) ? 16 : SECTION_INDEX_BITS;
   localparam logic [CNT_W-1:0] IDX_LIMIT = '1;

   logic [3:0]       phase_ff, phase_in;
   logic [2:0]       fcount_ff, fcount_in;
   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      sections_left_ff, sections_left_in;
   logic [63:0]      declared_ff, declared_in;
   logic [63:0]      payload_left_ff, payload_left_in;
   logic [CNT_W-1:0] section_ff, section_in;
   logic             bad_magic_ff, bad_magic_in;
   logic             bad_version_ff, bad_version_in;
   logic             crc_present_ff, crc_present_in;

   logic [3:0]  cnt_inc;
   logic [63:0] acc_new;
   logic [63:0] left_dec;
   logic        complete;
   logic [63:0] value;
   logic        end_sec;

   // Field assembly, phase sequencing and section bookkeeping for one byte.
   always_comb begin
      phase_in         = phase_ff;
      fcount_in        = fcount_ff;
      acc_in           = acc_ff;
      sections_left_in = sections_left_ff;
      declared_in      = declared_ff;
      payload_left_in  = payload_left_ff;
      section_in       = section_ff;
      bad_magic_in     = bad_magic_ff;
      bad_version_in   = bad_version_ff;
      crc_present_in   = crc_present_ff;
      complete         = 1'b0;
      value            = 64'd0;
      end_sec          = 1'b0;
      left_dec         = sections_left_ff;
      cnt_inc          = {1'b0, fcount_ff} + 4'd1;
      acc_new          = acc_ff | ({56'd0, data_byte} << {fcount_ff, 3'b000});

      if (phase_ff <= acd_pkg::PH_PAYLOAD_SIZE) begin
         if (cnt_inc >= acd_pkg::field_width(phase_ff)) begin
            complete  = 1'b1;
            value     = acc_new;
            acc_in    = 64'd0;
            fcount_in = 3'd0;
            case (phase_ff)
               acd_pkg::PH_MAGIC: begin
                  if (acc_new != {32'd0, regs.magic}) bad_magic_in = 1'b1;
                  phase_in = acd_pkg::PH_VERSION;
               end
               acd_pkg::PH_VERSION: begin
                  if (acc_new < {32'd0, regs.min_version} ||
                      acc_new > {32'd0, regs.max_version}) bad_version_in = 1'b1;
                  phase_in = acd_pkg::PH_FLAGS;
               end
               acd_pkg::PH_FLAGS: begin
                  crc_present_in = acc_new[0];
                  phase_in       = acd_pkg::PH_COUNT;
               end
               acd_pkg::PH_COUNT: begin
                  declared_in      = acc_new;
                  sections_left_in = acc_new;
                  phase_in = (acc_new != 64'd0) ? acd_pkg::PH_TYPE : acd_pkg::PH_TRAILER;
               end
               acd_pkg::PH_PAYLOAD_SIZE: begin
                  payload_left_in = acc_new;
                  if (acc_new != 64'd0) phase_in = acd_pkg::PH_PAYLOAD;
                  else end_sec = 1'b1;
               end
               default: begin
                  phase_in = phase_ff + 4'd1;
               end
            endcase
         end else begin
            acc_in    = acc_new;
            fcount_in = cnt_inc[2:0];
         end
      end else if (phase_ff == acd_pkg::PH_PAYLOAD) begin
         if (payload_left_ff != 64'd0) payload_left_in = payload_left_ff - 64'd1;
         if (payload_left_in == 64'd0) end_sec = 1'b1;
      end

      // Closing a section advances the index and picks the next phase.
      if (end_sec) begin
         if (section_ff != IDX_LIMIT) section_in = section_ff + 1'b1;
         if (sections_left_ff != 64'd0) left_dec = sections_left_ff - 64'd1;
         sections_left_in = left_dec;
         phase_in = (left_dec != 64'd0) ? acd_pkg::PH_TYPE : acd_pkg::PH_TRAILER;
      end

      result.kind          = phase_ff;
      result.complete      = complete;
      result.value         = value;
      result.section       = 16'(section_ff);
      result.phase_next    = phase_in;
      result.declared_next = declared_in;
      result.bad_magic     = bad_magic_in;
      result.bad_version   = bad_version_in;
      result.crc_present   = crc_present_in;
   end

   // Everything returns to its reset value after the final byte.
   always_ff @(posedge clock) begin
      if (reset || (advance && clear)) begin
         phase_ff         <= acd_pkg::PH_MAGIC;
         fcount_ff        <= 3'd0;
         acc_ff           <= 64'd0;
         sections_left_ff <= 64'd0;
         declared_ff      <= 64'd0;
         payload_left_ff  <= 64'd0;
         section_ff       <= '0;
         bad_magic_ff     <= 1'b0;
         bad_version_ff   <= 1'b0;
         crc_present_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         fcount_ff        <= fcount_in;
         acc_ff           <= acc_in;
         sections_left_ff <= sections_left_in;
         declared_ff      <= declared_in;
         payload_left_ff  <= payload_left_in;
         section_ff       <= section_in;
         bad_magic_ff     <= bad_magic_in;
         bad_version_ff   <= bad_version_in;
         crc_present_ff   <= crc_present_in;
      end
   end

endmodule

>>> rtl/acd_checker.sv
`include "assert_macros.svh"

module acd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_field_complete,
   input logic [63:0] rsp_field_value,
   input logic        rsp_archive_end,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_byte_out
);

   // A stalled response keeps its byte.
   `ACD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte_out), "response changed while stalled")

   // Every accepted request shows a response in the next cycle.
   `ACD_ASSERT_NEXT(a_req_to_rsp, req_valid && req_ready, rsp_valid, "accepted request gave no response")

   // Status is reported only with the final byte.
   `ACD_ASSERT_NOW(a_status_end, rsp_valid && !rsp_archive_end, rsp_status == acd_pkg::ST_OK, "status outside archive end")

   // Field value is zero unless a field completes.
   `ACD_ASSERT_NOW(a_value_zero, rsp_valid && !rsp_field_complete, rsp_field_value == 64'd0, "field value without completion")

endmodule

bind archive_container_deframer_core acd_checker u_acd_checker (.*);
